@@ rtl/assert_macros.svh @@
// Assertion macros shared by the ramp table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ rtl/mclt_pkg.sv @@
// Package with types, constants and codes of the ramp table.
package mclt_pkg;

    localparam int MaxRamps = 16;
    localparam int FracBits = 16;

    localparam logic [1:0] REQ_CREATE = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_SPARE  = 2'd3;

    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         target_id;
        logic signed [31:0] ramp_start;
        logic signed [31:0] ramp_end;
        logic [31:0]        ramp_duration;
        logic               has_callback;
        logic [31:0]        tick_delta;
    } t_req;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [7:0]         out_target;
        logic signed [31:0] out_value;
        logic               ramp_done;
        logic               notify_done;
        logic               last_result;
    } t_res;

    // Entry word: flag, target, start, end, length, born.
    typedef struct packed {
        logic        cb;
        logic [7:0]  tgt;
        logic [31:0] start;
        logic [31:0] fin;
        logic [31:0] len;
        logic [31:0] born;
    } t_entry;

    localparam int EntryW = $bits(t_entry);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_DIV,
        ST_MUL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

endpackage

@@ rtl/mclt_ram.sv @@
// Generic single-port-write, registered-read RAM.
module mclt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/mclt_div.sv @@
// Restoring divider: floor((num << FracBits) / den), one quotient bit per cycle.
module mclt_div
    import mclt_pkg::*;
#(
    parameter int FracW = FracBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [FracW:0] o_quot
);
    localparam int NumW = 32 + FracW;
    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] r_num, n_num;
    logic [32:0]     r_rem, n_rem;
    logic [31:0]     r_den, n_den;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [32:0]     w_try;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_try  = {r_rem[31:0], r_num[NumW-1]} - {1'b0, r_den};
        if (i_req.start) begin
            n_num  = {i_req.num, FracW'(0)};
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = CntW'(NumW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_try[32]) begin
                n_rem = w_try;
                n_num = {r_num[NumW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[31:0], r_num[NumW-1]};
                n_num = {r_num[NumW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num[FracW:0];
endmodule

@@ rtl/multi_channel_linear_tween.sv @@
// Top level of the multi-channel linear ramp table.
//
//  channel  | handshake              | payload
//  request  | start, busy            | i_req  (t_req)
//  result   | o_valid (one cycle)    | o_res  (t_res)
//
// Create and clear are taken without raising busy; a create result is registered
// and appears in the cycle after its transfer. A tick on a non-empty table holds
// busy while each entry in turn passes read, calc, mul and emit, with a divide on
// the shared divider between calc and mul when the entry is mid-ramp.
// Reset is synchronous and empties the table; the entry memory is not cleared.
// Results go out one per cycle slot with no stall from the receiver.
`include "assert_macros.svh"
module multi_channel_linear_tween
    import mclt_pkg::*;
#(
    parameter int MAX_RAMPS = MaxRamps,
    parameter int FRAC_BITS = FracBits
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_res o_res
);
    localparam int AW = (MAX_RAMPS > 1) ? $clog2(MAX_RAMPS) : 1;
    localparam int CW = $clog2(MAX_RAMPS + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_wr, n_wr;
    logic [31:0]     r_elapsed, n_elapsed;
    t_entry          r_ent, n_ent;
    logic            r_done_f, n_done_f;
    logic [FRAC_BITS:0] r_t, n_t;
    logic signed [32+FRAC_BITS+1:0] r_prod, n_prod;
    logic            r_valid, n_valid;
    t_res            r_res, n_res;

    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    t_entry          w_wdata, w_rdata;
    logic [EntryW-1:0] w_rraw;
    t_div_req        w_div;
    logic            w_div_done;
    logic [FRAC_BITS:0] w_quot;
    logic [32:0]     w_sum;
    logic signed [32:0] w_diff;
    logic signed [32+FRAC_BITS+1:0] w_q;

    mclt_ram #(.Width(EntryW), .Depth(MAX_RAMPS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rraw)
    );
    assign w_rdata = t_entry'(w_rraw);

    mclt_div #(.FracW(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_elapsed <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_elapsed <= n_elapsed;
            r_valid   <= n_valid;
        end
        r_rd     <= n_rd;
        r_wr     <= n_wr;
        r_ent    <= n_ent;
        r_done_f <= n_done_f;
        r_t      <= n_t;
        r_prod   <= n_prod;
        r_res    <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_elapsed = r_elapsed;
        n_ent     = r_ent;
        n_done_f  = r_done_f;
        n_t       = r_t;
        n_prod    = r_prod;
        n_valid   = 1'b0;
        n_res     = r_res;
        w_we      = 1'b0;
        w_waddr   = r_wr[AW-1:0];
        w_wdata   = r_ent;
        w_raddr   = r_rd[AW-1:0];
        w_div     = '0;
        w_sum     = {1'b0, r_elapsed} + {1'b0, i_req.tick_delta};
        w_diff    = $signed({r_ent.fin[31], r_ent.fin}) - $signed({r_ent.start[31], r_ent.start});
        w_q       = r_prod >>> FRAC_BITS;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_req.req_type)
                        REQ_CREATE: begin
                            n_valid = 1'b1;
                            n_res   = '{result_kind: KIND_REJECT, out_target: i_req.target_id,
                                        out_value: '0, ramp_done: 1'b0, notify_done: 1'b0,
                                        last_result: 1'b1};
                            if (r_count < CW'(MAX_RAMPS)) begin
                                w_we    = 1'b1;
                                w_waddr = r_count[AW-1:0];
                                w_wdata = '{cb: i_req.has_callback, tgt: i_req.target_id,
                                            start: i_req.ramp_start, fin: i_req.ramp_end,
                                            len: i_req.ramp_duration, born: r_elapsed};
                                n_count = r_count + 1'b1;
                                n_res.result_kind = KIND_ACCEPT;
                            end
                        end
                        REQ_TICK: begin
                            if (r_count == '0) begin
                                n_elapsed = '0;
                            end else begin
                                n_elapsed = w_sum[32] ? '1 : w_sum[31:0];
                                n_rd      = '0;
                                n_wr      = '0;
                                n_state   = ST_READ;
                            end
                        end
                        REQ_CLEAR: begin
                            n_count   = '0;
                            n_elapsed = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                n_ent    = w_rdata;
                n_done_f = (r_elapsed - w_rdata.born) > w_rdata.len;
                if (w_rdata.len == '0 || (r_elapsed - w_rdata.born) >= w_rdata.len) begin
                    n_t     = {1'b1, FRAC_BITS'(0)};
                    n_state = ST_MUL;
                end else begin
                    w_div.start = 1'b1;
                    w_div.num   = r_elapsed - w_rdata.born;
                    w_div.den   = w_rdata.len;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_t     = w_quot;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = w_diff * $signed({1'b0, r_t});
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_valid = 1'b1;
                n_res   = '{result_kind: KIND_UPDATE, out_target: r_ent.tgt,
                            out_value: r_ent.start + w_q[31:0], ramp_done: r_done_f,
                            notify_done: r_done_f & r_ent.cb,
                            last_result: (r_rd + 1'b1) == r_count};
                if (!r_done_f) begin
                    w_we    = 1'b1;
                    w_waddr = r_wr[AW-1:0];
                    w_wdata = r_ent;
                    n_wr    = r_wr + 1'b1;
                end
                n_rd = r_rd + 1'b1;
                if ((r_rd + 1'b1) == r_count) begin
                    n_count = r_done_f ? r_wr : r_wr + 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    `ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_RAMPS))
    `ASSERT_IMP(a_wr_le_rd, i_clk, i_rst_n, r_state != ST_IDLE, r_wr <= r_rd)
    `ASSERT_NXT(a_emit_valid, i_clk, i_rst_n, r_state == ST_EMIT, o_valid)
endmodule

@@ tb/sv/ramp_checker.sv @@
// Checker for the ramp table: predicts results per accepted request and compares them.
module ramp_checker
    import mclt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_req i_req,
    input  logic i_valid,
    input  t_res i_res,
    output int   o_errors,
    output int   o_pending,
    output int   o_updates,
    output int   o_finished
);

    logic [8:0]  tab_tgt [MaxRamps];
    logic [31:0] tab_start [MaxRamps];
    logic [31:0] tab_end [MaxRamps];
    logic [31:0] tab_len [MaxRamps];
    logic [31:0] tab_born [MaxRamps];
    int          tab_count;
    logic [31:0] clock_now;
    t_res        expected_q[$];

    function automatic logic [31:0] lerp(logic [31:0] s, logic [31:0] e, logic [32:0] t);
        longint a;
        longint d;
        longint p;
        longint q;
        a = longint'(signed'(s));
        d = longint'(signed'(e)) - a;
        p = d * longint'(t);
        q = p >>> FracBits;
        return 32'(a + q);
    endfunction

    task automatic predict(input t_req r);
        t_res        x;
        logic [31:0] age;
        logic [32:0] t;
        logic [32:0] sum;
        int          wr;
        logic        done;
        if (r.req_type == REQ_CREATE) begin
            x = '0;
            x.out_target = r.target_id;
            x.last_result = 1'b1;
            x.result_kind = KIND_REJECT;
            if (tab_count < MaxRamps) begin
                tab_tgt[tab_count] = {r.has_callback, r.target_id};
                tab_start[tab_count] = r.ramp_start;
                tab_end[tab_count] = r.ramp_end;
                tab_len[tab_count] = r.ramp_duration;
                tab_born[tab_count] = clock_now;
                tab_count++;
                x.result_kind = KIND_ACCEPT;
            end
            expected_q.insert(expected_q.size(), x);
        end else if (r.req_type == REQ_CLEAR) begin
            tab_count = 0;
            clock_now = '0;
        end else if (r.req_type == REQ_TICK) begin
            if (tab_count == 0) begin
                clock_now = '0;
            end else begin
                sum = {1'b0, clock_now} + {1'b0, r.tick_delta};
                clock_now = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                wr = 0;
                for (int rd = 0; rd < tab_count; rd++) begin
                    age = clock_now - tab_born[rd];
                    done = age > tab_len[rd];
                    if (tab_len[rd] == 0 || age >= tab_len[rd])
                        t = 33'(1) << FracBits;
                    else
                        t = 33'(({32'b0, age} << FracBits) / {32'b0, tab_len[rd]});
                    x = '0;
                    x.result_kind = KIND_UPDATE;
                    x.out_target = tab_tgt[rd][7:0];
                    x.out_value = lerp(tab_start[rd], tab_end[rd], t);
                    x.ramp_done = done;
                    x.notify_done = done & tab_tgt[rd][8];
                    expected_q.insert(expected_q.size(), x);
                    if (!done) begin
                        tab_tgt[wr] = tab_tgt[rd];
                        tab_start[wr] = tab_start[rd];
                        tab_end[wr] = tab_end[rd];
                        tab_len[wr] = tab_len[rd];
                        tab_born[wr] = tab_born[rd];
                        wr++;
                    end
                end
                tab_count = wr;
                expected_q[expected_q.size() - 1].last_result = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            tab_count = 0;
            clock_now = '0;
            expected_q.delete();
            o_errors = 0;
            o_updates = 0;
            o_finished = 0;
        end else begin
            if (i_valid) begin
                if (expected_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result %h", $time, i_res);
                end else begin
                    want = expected_q.pop_front();
                    if (want !== i_res) begin
                        o_errors++;
                        $display("%0t: mismatch expected %h actual %h", $time, want, i_res);
                    end
                    if (want.result_kind == KIND_UPDATE) o_updates++;
                    if (want.ramp_done) o_finished++;
                end
            end
            if (i_start && !i_busy) predict(i_req);
        end
        o_pending = expected_q.size();
    end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top: drives ramp requests into the ramp table and gives the verdict.
module tb;
    import mclt_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_valid;
    t_res o_res;
    int   errors;
    int   pending;
    int   updates;
    int   finished;
    int   sent;

    multi_channel_linear_tween i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_req(i_req),
        .busy(busy), .o_valid(o_valid), .o_res(o_res)
    );

    ramp_checker i_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_req(i_req), .i_valid(o_valid), .i_res(o_res), .o_errors(errors),
        .o_pending(pending), .o_updates(updates), .o_finished(finished)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic transfer(input t_req r);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(posedge i_clk);
        i_req <= r;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 1'b0;
        sent++;
    endtask

    // Hold until every expected result has come, then realign to the rising edge.
    task automatic drain();
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic create(input logic [7:0] tg, input logic [31:0] s, input logic [31:0] e,
                          input logic [31:0] d, input logic cb);
        t_req r;
        r = '0;
        r.req_type = REQ_CREATE;
        r.target_id = tg;
        r.ramp_start = s;
        r.ramp_end = e;
        r.ramp_duration = d;
        r.has_callback = cb;
        r.tick_delta = $urandom;
        transfer(r);
    endtask

    task automatic tick(input logic [31:0] dt);
        t_req r;
        r = '0;
        r.req_type = REQ_TICK;
        r.tick_delta = dt;
        r.target_id = 8'($urandom);
        r.ramp_start = $urandom;
        transfer(r);
    endtask

    task automatic other(input logic [1:0] code);
        t_req r;
        r = '0;
        r.req_type = code;
        r.ramp_end = $urandom;
        r.ramp_duration = $urandom;
        transfer(r);
    endtask

    initial begin
        int n;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        sent = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tick(32'h0001_0000);
        create(8'h00, 32'h0, 32'h0001_0000, 32'h0002_0000, 1'b1);
        create(8'hFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        create(8'h55, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1);
        create(8'hAA, 32'hFFFF_0000, 32'h0003_0000, 32'h0000_0001, 1'b0);
        tick(32'h0);
        tick(32'h0000_8000);
        tick(32'hFFFF_FFFF);
        tick(32'h1);
        for (int i = 0; i < 17; i++)
            create(8'(i), $urandom, $urandom, 32'hFFFF_FFFF, i[0]);
        tick(32'h0000_0100);
        other(REQ_CLEAR);
        other(REQ_SPARE);
        tick(32'h10);
        drain();

        for (int b = 0; b < 12; b++) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                create(8'($urandom), rand_word(), rand_word(),
                       ($urandom_range(0, 3) == 0) ? rand_word() : $urandom_range(0, 32'h8_0000),
                       1'($urandom));
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
                tick(($urandom_range(0, 7) == 0) ? rand_word() : $urandom_range(0, 32'h4_0000));
            case ($urandom_range(0, 5))
                0: other(REQ_CLEAR);
                1: other(REQ_SPARE);
                default: ;
            endcase
            if (b == 6) drain();
        end

        drain();
        repeat (1000) @(posedge i_clk);
        $display("Sent %0d requests; checked %0d ramp updates, %0d ramps finished.",
                 sent, updates, finished);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/mclt_pkg.sv
rtl/mclt_ram.sv
rtl/mclt_div.sv
rtl/multi_channel_linear_tween.sv
tb/sv/ramp_checker.sv
tb/sv/tb.sv
